>>> hw/rtl/ifr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifr_pkg
// Shared types and constants of the information frame receiver.
// ----------------------------------------------------------------------------
package ifr_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_FLAG_BYTE    = 3'd0;
  localparam logic [2:0] REG_ADDRESS_BYTE = 3'd1;
  localparam logic [2:0] REG_CONTROL_SEQ0 = 3'd2;
  localparam logic [2:0] REG_CONTROL_SEQ1 = 3'd3;
  localparam logic [2:0] REG_MAX_PAYLOAD  = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [7:0]  FLAG_RESET    = 8'h7E;
  localparam logic [7:0]  ADDRESS_RESET = 8'h03;
  localparam logic [7:0]  SEQ0_RESET    = 8'h00;
  localparam logic [7:0]  SEQ1_RESET    = 8'h40;
  localparam logic [12:0] MAXPAY_RESET  = 13'd4096;

  // Input word modes.
  localparam logic MODE_BYTE    = 1'b0;
  localparam logic MODE_RESTART = 1'b1;

  // Largest value the 13-bit byte count can hold.
  localparam int unsigned COUNT_MAX = 8191;

  // Queue between the classifier and the phase engine.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = 1;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_FLAG  = 3'd1,
    PH_ADDR  = 3'd2,
    PH_CTRL  = 3'd3,
    PH_BCC1  = 3'd4,
    PH_DATA  = 3'd5,
    PH_STOP  = 3'd6,
    PH_ERROR = 3'd7
  } phase_t;

  // A received word after comparison against the configured bytes.
  typedef struct packed {
    logic       restart;
    logic       is_flag;
    logic       is_addr;
    logic       is_seq0;
    logic       is_seq1;
    logic       is_bcc0;
    logic       is_bcc1;
    logic [7:0] rx_byte;
  } class_t;

  // One result word.
  typedef struct packed {
    logic [12:0] payload_length;
    logic        sequence_bit;
    logic [11:0] payload_position;
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic [2:0]  phase;
  } result_t;

endpackage

>>> hw/rtl/ifr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifr_front
// Configuration registers and per-byte classification of received words.
// ----------------------------------------------------------------------------
module ifr_front #(
  parameter int unsigned PAYLOAD_LIMIT = 4096
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [12:0]     cfg_data,
  input  logic            mode,
  input  logic [7:0]      rx_byte,
  output ifr_pkg::class_t item,
  output logic [12:0]     limit
);

  localparam int unsigned LIMIT_CAP =
    (PAYLOAD_LIMIT > ifr_pkg::COUNT_MAX) ? ifr_pkg::COUNT_MAX : PAYLOAD_LIMIT;
  localparam logic [12:0] LIMIT_CAP13 = 13'(LIMIT_CAP);

  logic [7:0]  flag_byte;
  logic [7:0]  address_byte;
  logic [7:0]  control_seq0;
  logic [7:0]  control_seq1;
  logic [12:0] max_payload;

  always_ff @(posedge clk) begin
    if (rst) begin
      flag_byte    <= ifr_pkg::FLAG_RESET;
      address_byte <= ifr_pkg::ADDRESS_RESET;
      control_seq0 <= ifr_pkg::SEQ0_RESET;
      control_seq1 <= ifr_pkg::SEQ1_RESET;
      max_payload  <= ifr_pkg::MAXPAY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ifr_pkg::REG_FLAG_BYTE:    flag_byte    <= cfg_data[7:0];
        ifr_pkg::REG_ADDRESS_BYTE: address_byte <= cfg_data[7:0];
        ifr_pkg::REG_CONTROL_SEQ0: control_seq0 <= cfg_data[7:0];
        ifr_pkg::REG_CONTROL_SEQ1: control_seq1 <= cfg_data[7:0];
        ifr_pkg::REG_MAX_PAYLOAD:  max_payload  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Both BCC1 candidates are checked here; the phase engine picks one by the
  // sequence it holds.
  always_comb begin
    item.restart = (mode == ifr_pkg::MODE_RESTART);
    item.is_flag = (rx_byte == flag_byte);
    item.is_addr = (rx_byte == address_byte);
    item.is_seq0 = (rx_byte == control_seq0);
    item.is_seq1 = (rx_byte == control_seq1);
    item.is_bcc0 = (rx_byte == (address_byte ^ control_seq0));
    item.is_bcc1 = (rx_byte == (address_byte ^ control_seq1));
    item.rx_byte = rx_byte;
  end

  assign limit = (max_payload > LIMIT_CAP13) ? LIMIT_CAP13 : max_payload;

endmodule

>>> hw/rtl/ifr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifr_queue
// Short queue of classified words between the classifier and phase engine.
// ----------------------------------------------------------------------------
module ifr_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ifr_pkg::class_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            nonempty,
  output ifr_pkg::class_t pop_item
);

  localparam logic [ifr_pkg::QUEUE_AW:0] DEPTH_N = (ifr_pkg::QUEUE_AW + 1)'(ifr_pkg::QUEUE_DEPTH);

  ifr_pkg::class_t mem [ifr_pkg::QUEUE_DEPTH];

  logic [ifr_pkg::QUEUE_AW-1:0] wr_ptr;
  logic [ifr_pkg::QUEUE_AW-1:0] rd_ptr;
  logic [ifr_pkg::QUEUE_AW:0]   count;

  assign full     = (count == DEPTH_N);
  assign nonempty = (count != '0);
  assign pop_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/ifr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifr_back
// Receive phase engine, payload counter and registered result word.
// ----------------------------------------------------------------------------
module ifr_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  ifr_pkg::class_t  in_item,
  output logic             in_pop,
  input  logic [12:0]      limit,
  output logic             out_valid,
  input  logic             out_ready,
  output ifr_pkg::result_t out_word
);

  ifr_pkg::phase_t phase;
  ifr_pkg::phase_t phase_next;
  logic            sequence_held;
  logic            sequence_held_next;
  logic [12:0]     byte_count;
  logic [12:0]     byte_count_next;
  logic            stored;
  logic            bcc_ok;

  assign in_pop = in_valid && (!out_valid || out_ready);
  assign bcc_ok = sequence_held ? in_item.is_bcc1 : in_item.is_bcc0;

  // Next phase.
  always_comb begin
    phase_next = phase;
    if (in_item.restart) begin
      phase_next = ifr_pkg::PH_START;
    end else begin
      unique case (phase)
        ifr_pkg::PH_START: begin
          if (in_item.is_flag) phase_next = ifr_pkg::PH_FLAG;
        end
        ifr_pkg::PH_FLAG: begin
          priority if (in_item.is_addr) phase_next = ifr_pkg::PH_ADDR;
          else if (!in_item.is_flag)    phase_next = ifr_pkg::PH_START;
          else                          phase_next = ifr_pkg::PH_FLAG;
        end
        ifr_pkg::PH_ADDR: begin
          priority if (in_item.is_seq0 || in_item.is_seq1) phase_next = ifr_pkg::PH_CTRL;
          else if (in_item.is_flag) phase_next = ifr_pkg::PH_FLAG;
          else                      phase_next = ifr_pkg::PH_START;
        end
        ifr_pkg::PH_CTRL: begin
          priority if (bcc_ok)      phase_next = ifr_pkg::PH_BCC1;
          else if (in_item.is_flag) phase_next = ifr_pkg::PH_FLAG;
          else                      phase_next = ifr_pkg::PH_START;
        end
        ifr_pkg::PH_BCC1, ifr_pkg::PH_DATA: begin
          priority if (in_item.is_flag) begin
            phase_next = (phase == ifr_pkg::PH_BCC1) ? ifr_pkg::PH_FLAG : ifr_pkg::PH_STOP;
          end else if (byte_count < limit) begin
            phase_next = ifr_pkg::PH_DATA;
          end else begin
            phase_next = ifr_pkg::PH_ERROR;
          end
        end
        ifr_pkg::PH_STOP, ifr_pkg::PH_ERROR: ;
        default: ;
      endcase
    end
  end

  // Sequence, payload count and store decision.
  always_comb begin
    sequence_held_next = sequence_held;
    byte_count_next    = byte_count;
    stored             = 1'b0;
    if (in_item.restart) begin
      byte_count_next = '0;
    end else begin
      if (phase == ifr_pkg::PH_ADDR) begin
        priority if (in_item.is_seq0) sequence_held_next = 1'b0;
        else if (in_item.is_seq1)     sequence_held_next = 1'b1;
        else                          sequence_held_next = sequence_held;
      end
      if ((phase == ifr_pkg::PH_BCC1 || phase == ifr_pkg::PH_DATA) &&
          !in_item.is_flag && byte_count < limit) begin
        stored          = 1'b1;
        byte_count_next = byte_count + 13'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= ifr_pkg::PH_START;
      sequence_held <= 1'b0;
      byte_count    <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (in_pop) begin
        phase         <= phase_next;
        sequence_held <= sequence_held_next;
        byte_count    <= byte_count_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_pop) begin
      out_word.phase            <= phase_next;
      out_word.payload_valid    <= stored;
      out_word.payload_byte     <= stored ? in_item.rx_byte : 8'd0;
      out_word.payload_position <= stored ? byte_count[11:0] : 12'd0;
      out_word.sequence_bit     <= sequence_held_next;
      out_word.payload_length   <= byte_count_next;
    end
  end

endmodule

>>> hw/rtl/information_frame_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// information_frame_receiver
// Path: a word accepted on the input is written into the queue and then
// loaded into the output register when the output is not stalled.
// Throughput: one word per cycle while the output is not stalled.
// Reset: synchronous; registers take their defaults, phase goes to start,
// sequence and payload count to zero, queue and output empty.
// ----------------------------------------------------------------------------
module information_frame_receiver #(
  parameter int unsigned PAYLOAD_LIMIT = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        s_tuser,   // [0] mode
  output logic        m_tvalid,
  input  logic        m_tready,
  // [2:0] phase, [10:3] payload_byte, [22:11] payload_position,
  // [23] sequence_bit, [36:24] payload_length, [39:37] zero
  output logic [39:0] m_tdata,
  output logic        m_tuser    // [0] payload_valid
);

  ifr_pkg::class_t  front_item;
  ifr_pkg::class_t  queue_item;
  ifr_pkg::result_t result;
  logic [12:0]      limit;
  logic             queue_full;
  logic             queue_nonempty;
  logic             queue_pop;

  assign s_tready = !queue_full;

  ifr_front #(
    .PAYLOAD_LIMIT(PAYLOAD_LIMIT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .mode     (s_tuser),
    .rx_byte  (s_tdata),
    .item     (front_item),
    .limit    (limit)
  );

  ifr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (s_tvalid && s_tready),
    .push_item(front_item),
    .full     (queue_full),
    .pop      (queue_pop),
    .nonempty (queue_nonempty),
    .pop_item (queue_item)
  );

  ifr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (queue_nonempty),
    .in_item  (queue_item),
    .in_pop   (queue_pop),
    .limit    (limit),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_word (result)
  );

  assign m_tdata = {3'd0, result.payload_length, result.sequence_bit,
                    result.payload_position, result.payload_byte, result.phase};
  assign m_tuser = result.payload_valid;

endmodule
